>>> hdl/acvc_pkg.sv
// shared types, constants and helpers of the visible clip unit
`default_nettype none
package acvc_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BEL     = 8'h07;
  localparam logic [7:0] CH_OSC     = 8'h5D;
  localparam logic [7:0] CH_CSI     = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SGR     = 8'h6D;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7E;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CODE_CONT  = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

  localparam logic [2:0] APB_ADDR_LIMIT = 3'd0;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_OSC,
    MODE_OSC_ESC,
    MODE_CSI
  } esc_mode_t;

  typedef enum logic [2:0] {
    PH_BYTE,
    PH_ESC,
    PH_BRACKET,
    PH_ZERO,
    PH_M
  } out_phase_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        emit;
    logic        last;
    logic        any;
    logic [15:0] kept;
    logic [15:0] total;
  } cmd_t;

  function automatic count_t sat_inc(input count_t v);
    if (32'(v) >= COUNT_MAX) begin
      return v;
    end
    return v + count_t'(1);
  endfunction

  function automatic logic [15:0] sat16(input count_t v);
    if (32'(v) > 32'h0000_FFFF) begin
      return 16'hFFFF;
    end
    return 16'(32'(v));
  endfunction

  function automatic logic [1:0] char_tail(input logic [7:0] lead);
    if (!lead[7]) begin
      return 2'd0;
    end
    if ((lead & MASK_LEAD2) == MASK_CONT) begin
      return 2'd1;
    end
    if ((lead & MASK_LEAD3) == CODE_LEAD3) begin
      return 2'd2;
    end
    if ((lead & MASK_LEAD4) == CODE_LEAD4) begin
      return 2'd3;
    end
    return 2'd0;
  endfunction

endpackage
`default_nettype wire

>>> hdl/acvc_front.sv
// front end: escape and utf-8 parser, visible counters and clip decision
`default_nettype none
module acvc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire logic [7:0]           text_byte,
  input  wire logic                 end_of_text,
  input  wire logic [15:0]          visible_limit,
  output acvc_pkg::cmd_t            cmd
);

  acvc_pkg::esc_mode_t mode, mode_next;
  logic [1:0]          cont_left, cont_left_next;
  acvc_pkg::count_t    kept, kept_next;
  acvc_pkg::count_t    total, total_next;
  logic                stopped, stopped_next;
  logic                any, any_next;
  logic                do_plain;
  logic                keep;
  logic                emit;

  // bytes that fall back to plain text parsing
  always_comb begin
    do_plain = 1'b0;
    if (cont_left == 2'd0) begin
      unique case (mode)
        acvc_pkg::MODE_PLAIN: do_plain = 1'b1;
        acvc_pkg::MODE_ESC:
          do_plain = (text_byte != acvc_pkg::CH_OSC) && (text_byte != acvc_pkg::CH_CSI);
        default: do_plain = 1'b0;
      endcase
    end
  end

  // parser next state
  always_comb begin
    mode_next = mode;
    if (cont_left == 2'd0) begin
      if (do_plain) begin
        mode_next = (text_byte == acvc_pkg::CH_ESC) ? acvc_pkg::MODE_ESC
                                                    : acvc_pkg::MODE_PLAIN;
      end else begin
        unique case (mode)
          acvc_pkg::MODE_ESC: begin
            mode_next = (text_byte == acvc_pkg::CH_OSC) ? acvc_pkg::MODE_OSC
                                                        : acvc_pkg::MODE_CSI;
          end
          acvc_pkg::MODE_OSC: begin
            if (text_byte == acvc_pkg::CH_BEL) begin
              mode_next = acvc_pkg::MODE_PLAIN;
            end else if (text_byte == acvc_pkg::CH_ESC) begin
              mode_next = acvc_pkg::MODE_OSC_ESC;
            end
          end
          acvc_pkg::MODE_OSC_ESC: begin
            if (text_byte == acvc_pkg::CH_BSLASH || text_byte == acvc_pkg::CH_BEL) begin
              mode_next = acvc_pkg::MODE_PLAIN;
            end else if (text_byte != acvc_pkg::CH_ESC) begin
              mode_next = acvc_pkg::MODE_OSC;
            end
          end
          acvc_pkg::MODE_CSI: begin
            if (text_byte >= acvc_pkg::FINAL_LO && text_byte <= acvc_pkg::FINAL_HI) begin
              mode_next = acvc_pkg::MODE_PLAIN;
            end
          end
          default: mode_next = acvc_pkg::MODE_PLAIN;
        endcase
      end
    end
  end

  // counters, clip decision and queue word
  always_comb begin
    cont_left_next = cont_left;
    kept_next      = kept;
    total_next     = total;
    stopped_next   = stopped;
    keep           = 1'b1;
    if (cont_left != 2'd0) begin
      cont_left_next = cont_left - 2'd1;
    end else if (do_plain && text_byte != acvc_pkg::CH_ESC) begin
      if ((text_byte & acvc_pkg::MASK_CONT) == acvc_pkg::CODE_CONT) begin
        keep = 1'b0;
      end else begin
        total_next     = acvc_pkg::sat_inc(total);
        cont_left_next = acvc_pkg::char_tail(text_byte);
        if (stopped) begin
          keep = 1'b0;
        end else if (32'(kept) >= 32'(visible_limit)) begin
          stopped_next = 1'b1;
          keep         = 1'b0;
        end else begin
          kept_next = acvc_pkg::sat_inc(kept);
        end
      end
    end
    emit      = keep && !stopped_next;
    any_next  = any || emit;
    cmd.data  = text_byte;
    cmd.emit  = emit;
    cmd.last  = end_of_text;
    cmd.any   = any_next;
    cmd.kept  = acvc_pkg::sat16(kept_next);
    cmd.total = acvc_pkg::sat16(total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= acvc_pkg::MODE_PLAIN;
      cont_left <= 2'd0;
      kept      <= '0;
      total     <= '0;
      stopped   <= 1'b0;
      any       <= 1'b0;
    end else if (take) begin
      if (end_of_text) begin
        mode      <= acvc_pkg::MODE_PLAIN;
        cont_left <= 2'd0;
        kept      <= '0;
        total     <= '0;
        stopped   <= 1'b0;
        any       <= 1'b0;
      end else begin
        mode      <= mode_next;
        cont_left <= cont_left_next;
        kept      <= kept_next;
        total     <= total_next;
        stopped   <= stopped_next;
        any       <= any_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/acvc_queue.sv
// short fifo of parsed words between front and back end
`default_nettype none
module acvc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire acvc_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output acvc_pkg::cmd_t       head,
  output logic                 empty,
  output logic                 full
);

  acvc_pkg::cmd_t                      entries [acvc_pkg::QUEUE_DEPTH];
  logic [acvc_pkg::QPTR_BITS-1:0]      wr_ptr;
  logic [acvc_pkg::QPTR_BITS-1:0]      rd_ptr;
  logic [acvc_pkg::QCNT_BITS-1:0]      count;

  assign empty = (count == '0);
  assign full  = (count == acvc_pkg::QCNT_BITS'(acvc_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + acvc_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + acvc_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + acvc_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - acvc_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/acvc_back.sv
// back end: expands queued words into output words and the closing reset sequence
`default_nettype none
module acvc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire acvc_pkg::cmd_t  head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [39:0]          m_tdata,  // out_byte, kept_visible, total_visible
  output logic                 m_tuser,  // byte_present
  output logic                 m_tlast   // out_end
);

  acvc_pkg::out_phase_t phase, phase_next, sel;
  logic                 out_free;
  logic                 word_valid;
  logic                 word_done;
  logic [7:0]           word_byte;
  logic                 word_present;
  logic                 word_end;
  logic                 skip;

  assign out_free = !m_tvalid || m_tready;
  assign skip     = !empty && (phase == acvc_pkg::PH_BYTE) && !head.emit && !head.last;
  assign sel      = ((phase == acvc_pkg::PH_BYTE) && !head.emit) ? acvc_pkg::PH_ESC : phase;

  // next phase
  always_comb begin
    phase_next = phase;
    if (!empty && !skip && out_free) begin
      unique case (sel)
        acvc_pkg::PH_BYTE:    phase_next = head.last ? acvc_pkg::PH_ESC : acvc_pkg::PH_BYTE;
        acvc_pkg::PH_ESC:     phase_next = head.any ? acvc_pkg::PH_BRACKET : acvc_pkg::PH_BYTE;
        acvc_pkg::PH_BRACKET: phase_next = acvc_pkg::PH_ZERO;
        acvc_pkg::PH_ZERO:    phase_next = acvc_pkg::PH_M;
        acvc_pkg::PH_M:       phase_next = acvc_pkg::PH_BYTE;
        default:              phase_next = acvc_pkg::PH_BYTE;
      endcase
    end
  end

  // word for the current phase
  always_comb begin
    word_byte    = 8'h00;
    word_present = 1'b1;
    word_end     = 1'b0;
    word_done    = 1'b0;
    unique case (sel)
      acvc_pkg::PH_BYTE: begin
        word_byte = head.data;
        word_done = !head.last;
      end
      acvc_pkg::PH_ESC: begin
        if (head.any) begin
          word_byte = acvc_pkg::CH_ESC;
        end else begin
          word_present = 1'b0;
          word_end     = 1'b1;
          word_done    = 1'b1;
        end
      end
      acvc_pkg::PH_BRACKET: word_byte = acvc_pkg::CH_CSI;
      acvc_pkg::PH_ZERO:    word_byte = acvc_pkg::CH_ZERO;
      acvc_pkg::PH_M: begin
        word_byte = acvc_pkg::CH_SGR;
        word_end  = 1'b1;
        word_done = 1'b1;
      end
      default: word_byte = 8'h00;
    endcase
    word_valid = !empty && !skip && out_free;
    pop        = skip || (word_valid && word_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= acvc_pkg::PH_BYTE;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (word_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid) begin
      m_tdata[7:0]   <= word_byte;
      m_tdata[23:8]  <= word_end ? head.kept : 16'h0000;
      m_tdata[39:24] <= word_end ? head.total : 16'h0000;
      m_tuser        <= word_present;
      m_tlast        <= word_end;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ansi_aware_visible_clip_unit.sv
// each accepted byte is written into the queue; a kept byte then goes from its head into the output register
// throughput: one byte per cycle while the queue has room; the last byte of a text adds up to four output words
//   (the closing reset sequence); the four-word queue takes part of them, then the input stalls
// the output side moves one word per cycle while m_tready is high, limited by the single output register
// reset: synchronous, active high; clears parser, counters and queue, limit goes to 80
`default_nettype none
module ansi_aware_visible_clip_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // text_byte
  input  wire logic        s_tlast,  // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // out_byte, kept_visible, total_visible
  output logic             m_tuser,  // byte_present
  output logic             m_tlast,  // out_end
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]    visible_limit;
  logic           take;
  logic           q_empty;
  logic           q_full;
  logic           q_pop;
  acvc_pkg::cmd_t front_cmd;
  acvc_pkg::cmd_t q_head;

  assign pready   = 1'b1;
  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;
  assign prdata   = (paddr == acvc_pkg::APB_ADDR_LIMIT) ? {16'h0000, visible_limit} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      visible_limit <= 16'd80;
    end else if (psel && penable && pwrite && pready &&
                 paddr == acvc_pkg::APB_ADDR_LIMIT) begin
      visible_limit <= pwdata[15:0];
    end
  end

  acvc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .text_byte     (s_tdata),
    .end_of_text   (s_tlast),
    .visible_limit (visible_limit),
    .cmd           (front_cmd)
  );

  acvc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  acvc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
